>>> src/swled_pkg.sv
// ----------------------------------------------------------------------------
// swled_pkg
// shared types, constants and the command script table for the single-wire
// led program sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package swled_pkg;

    // field widths
    localparam int KIND_W  = 3;
    localparam int TIME_W  = 16;
    localparam int DUR_W   = 17;
    localparam int PC_W    = 4;
    localparam int SUB_W   = 4;

    localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

    // fixed waveform timing
    localparam logic [DUR_W-1:0] STANDBY_US = DUR_W'(10000);
    localparam logic [DUR_W-1:0] CAL_GAP_US = DUR_W'(50);

    // pulses per command group
    localparam int GRP_START_N = 2;
    localparam int GRP_END_N   = 3;
    localparam int GRP_ONCE_N  = 4;

    // default timing parameters
    localparam int DEF_CMD_PULSE_HIGH_US = 10;
    localparam int DEF_CMD_PULSE_LOW_US  = 10;
    localparam int DEF_ENTER_WINDOW_US   = 200;
    localparam int DEF_BLANK_US          = 100;
    localparam int DEF_CAL_PULSE_US      = 200;
    localparam int DEF_ADJUST_US         = 10;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // command kinds
    localparam logic [KIND_W-1:0] KIND_STEADY_ON   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_OFF         = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FLASH       = 3'd2;
    localparam logic [KIND_W-1:0] KIND_FLASH_ONCE  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_SET_CURRENT = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [TIME_W-1:0] current_code;
        logic [TIME_W-1:0] rise_time;
        logic [TIME_W-1:0] fall_time;
        logic [TIME_W-1:0] on_time;
        logic [TIME_W-1:0] off_time;
        logic              use_default;
    } t_in_beat;

    typedef struct packed {
        logic             pin_level;
        logic [DUR_W-1:0] duration_us;
        logic             hold;
        logic             last;
    } t_out_beat;

    // one raw, unmerged segment as produced by the front
    typedef struct packed {
        logic             level;
        logic [DUR_W-1:0] dur;
        logic             hold;
    } t_raw_seg;

    // queue handshake between front/back and the queue
    typedef struct packed {
        logic avail;
        logic full;
    } t_queue_status;

    // waveform building blocks of a command
    typedef enum logic [3:0] {
        M_NONE,
        M_STBY,
        M_START,
        M_END,
        M_ONCE,
        M_CAL,
        M_CUR,
        M_RAMP,
        M_HOLD_HI,
        M_HOLD_LO
    } t_macro;

    // building block at step pc of a command
    function automatic t_macro script_op(
        input logic [KIND_W-1:0] kind,
        input logic              use_def,
        input logic [PC_W-1:0]   pc
    );
        t_macro op;
        op = M_NONE;
        case (kind)
            KIND_STEADY_ON: begin
                case (pc)
                    4'd0:    op = M_STBY;
                    4'd1:    op = M_START;
                    4'd2:    op = M_CAL;
                    4'd3:    op = M_END;
                    4'd4:    op = M_STBY;
                    4'd5:    op = M_START;
                    4'd6:    op = M_CAL;
                    4'd7:    op = M_CUR;
                    4'd8:    op = M_END;
                    4'd9:    op = M_STBY;
                    default: op = M_HOLD_HI;
                endcase
            end
            KIND_OFF: begin
                case (pc)
                    4'd0:    op = M_STBY;
                    4'd1:    op = M_START;
                    4'd2:    op = M_END;
                    4'd3:    op = M_STBY;
                    default: op = M_HOLD_LO;
                endcase
            end
            KIND_FLASH: begin
                if (use_def) begin
                    case (pc)
                        4'd0:    op = M_STBY;
                        4'd1:    op = M_START;
                        4'd2:    op = M_END;
                        4'd3:    op = M_STBY;
                        default: op = M_HOLD_HI;
                    endcase
                end else begin
                    case (pc)
                        4'd0:    op = M_STBY;
                        4'd1:    op = M_START;
                        4'd2:    op = M_END;
                        4'd3:    op = M_STBY;
                        4'd4:    op = M_START;
                        4'd5:    op = M_CAL;
                        4'd6:    op = M_CUR;
                        4'd7:    op = M_RAMP;
                        4'd8:    op = M_END;
                        default: op = M_HOLD_HI;
                    endcase
                end
            end
            KIND_FLASH_ONCE: begin
                case (pc)
                    4'd0:    op = M_STBY;
                    4'd1:    op = M_ONCE;
                    default: op = M_HOLD_LO;
                endcase
            end
            KIND_SET_CURRENT: begin
                case (pc)
                    4'd0:    op = M_START;
                    4'd1:    op = M_CAL;
                    4'd2:    op = M_CUR;
                    4'd3:    op = M_END;
                    default: op = M_HOLD_LO;
                endcase
            end
            default: op = M_NONE;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

>>> src/single_wire_led_program_sequencer_unit.sv
// ----------------------------------------------------------------------------
// single_wire_led_program_sequencer_unit
// turns one led command into the segment list of the single-wire control pin
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_stall / i_beat, one command per beat
//   output channel: o_valid / i_stall / o_beat, one pin segment per beat
//   a beat moves when valid is high and stall is low at a rising edge
//   the front expands a command into raw segments for a four-entry queue, one
//   per cycle unless the queue is full; the back merges equal-level neighbors,
//   drops empty segments and holds each result in an output register
//   the front stays busy while it expands a command, which gives the most raw
//   segments for flash with pattern and the fewest for flash once; the next
//   command is taken as soon as the front has queued the final held segment
//   of the previous one
//   every known kind ends with a held segment marked hold and last; an unknown
//   kind is taken and gives no segments
//   receiver stall: the output register holds, the queue fills, then the
//   front waits and o_stall stays high
//   reset (synchronous, active low): queue emptied, both sides idle
// ----------------------------------------------------------------------------
`default_nettype none

module single_wire_led_program_sequencer_unit #(
    parameter int CMD_PULSE_HIGH_US = swled_pkg::DEF_CMD_PULSE_HIGH_US,
    parameter int CMD_PULSE_LOW_US  = swled_pkg::DEF_CMD_PULSE_LOW_US,
    parameter int ENTER_WINDOW_US   = swled_pkg::DEF_ENTER_WINDOW_US,
    parameter int BLANK_US          = swled_pkg::DEF_BLANK_US,
    parameter int CAL_PULSE_US      = swled_pkg::DEF_CAL_PULSE_US,
    parameter int ADJUST_US         = swled_pkg::DEF_ADJUST_US
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    // command beats
    input  wire                  i_valid,
    output logic                 o_stall,
    input  swled_pkg::t_in_beat  i_beat,
    // segment beats
    output logic                 o_valid,
    input  wire                  i_stall,
    output swled_pkg::t_out_beat o_beat
);
    import swled_pkg::*;

    // front to queue
    logic          push;
    t_raw_seg      push_seg;
    // queue to back
    logic          pop;
    t_raw_seg      head_seg;
    t_queue_status q_status;

    // command decode and segment expansion
    swled_front #(
        .CMD_PULSE_HIGH_US (CMD_PULSE_HIGH_US),
        .CMD_PULSE_LOW_US  (CMD_PULSE_LOW_US),
        .ENTER_WINDOW_US   (ENTER_WINDOW_US),
        .BLANK_US          (BLANK_US),
        .CAL_PULSE_US      (CAL_PULSE_US),
        .ADJUST_US         (ADJUST_US)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_beat     (i_beat),
        .i_q_status (q_status),
        .o_push     (push),
        .o_push_seg (push_seg)
    );

    // decoupling queue, lets each side wait on its own
    swled_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_seg (push_seg),
        .i_pop      (pop),
        .o_head_seg (head_seg),
        .o_status   (q_status)
    );

    // merge, saturate and output register
    swled_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_head_seg (head_seg),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_beat     (o_beat)
    );

endmodule

`default_nettype wire

>>> src/swled_queue.sv
// ----------------------------------------------------------------------------
// swled_queue
// small fifo of raw segments between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module swled_queue (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_push,
    input  swled_pkg::t_raw_seg      i_push_seg,
    input  wire                      i_pop,
    output swled_pkg::t_raw_seg      o_head_seg,
    output swled_pkg::t_queue_status o_status
);
    import swled_pkg::*;

    t_raw_seg          r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QPTR_W:0]   r_count, n_count;
    logic              push_ok, pop_ok;

    assign push_ok = i_push && (r_count != (QPTR_W+1)'(QUEUE_DEPTH));
    assign pop_ok  = i_pop && (r_count != '0);

    always_comb begin
        n_wptr  = push_ok ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = pop_ok ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count + (QPTR_W+1)'(push_ok) - (QPTR_W+1)'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wptr] <= i_push_seg;
        end
    end

    assign o_head_seg      = r_mem[r_rptr];
    assign o_status.avail  = (r_count != '0);
    assign o_status.full   = (r_count == (QPTR_W+1)'(QUEUE_DEPTH));

endmodule

`default_nettype wire

>>> src/swled_front.sv
// ----------------------------------------------------------------------------
// swled_front
// accepts a command and expands it into raw pin segments, one per cycle unless the queue is full
// ----------------------------------------------------------------------------
`default_nettype none

module swled_front #(
    parameter int CMD_PULSE_HIGH_US = swled_pkg::DEF_CMD_PULSE_HIGH_US,
    parameter int CMD_PULSE_LOW_US  = swled_pkg::DEF_CMD_PULSE_LOW_US,
    parameter int ENTER_WINDOW_US   = swled_pkg::DEF_ENTER_WINDOW_US,
    parameter int BLANK_US          = swled_pkg::DEF_BLANK_US,
    parameter int CAL_PULSE_US      = swled_pkg::DEF_CAL_PULSE_US,
    parameter int ADJUST_US         = swled_pkg::DEF_ADJUST_US
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    output logic                     o_stall,
    input  swled_pkg::t_in_beat      i_beat,
    input  swled_pkg::t_queue_status i_q_status,
    output logic                     o_push,
    output swled_pkg::t_raw_seg      o_push_seg
);
    import swled_pkg::*;

    localparam int PulsePair = CMD_PULSE_HIGH_US + CMD_PULSE_LOW_US;
    localparam int GapStart  = ((ENTER_WINDOW_US > GRP_START_N * PulsePair) ?
                                ENTER_WINDOW_US - GRP_START_N * PulsePair : 0) + BLANK_US;
    localparam int GapEnd    = ((ENTER_WINDOW_US > GRP_END_N * PulsePair) ?
                                ENTER_WINDOW_US - GRP_END_N * PulsePair : 0) + BLANK_US;
    localparam int GapOnce   = ((ENTER_WINDOW_US > GRP_ONCE_N * PulsePair) ?
                                ENTER_WINDOW_US - GRP_ONCE_N * PulsePair : 0) + BLANK_US;

    localparam logic [DUR_W-1:0] PulseHi  = DUR_W'(CMD_PULSE_HIGH_US);
    localparam logic [DUR_W-1:0] PulseLo  = DUR_W'(CMD_PULSE_LOW_US);
    localparam logic [DUR_W-1:0] CalPulse = DUR_W'(CAL_PULSE_US);
    localparam logic [DUR_W-1:0] Adjust   = DUR_W'(ADJUST_US);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state            r_state, n_state;
    logic [PC_W-1:0]   r_pc, n_pc;
    logic [SUB_W-1:0]  r_sub, n_sub;
    logic [KIND_W-1:0] r_kind;
    logic              r_use_def;
    logic [DUR_W-1:0]  r_cur, r_rise, r_fall, r_on, r_off;

    t_macro            macro;
    t_raw_seg          seg;
    logic              done;
    logic [SUB_W-1:0]  grp_last;
    logic [DUR_W-1:0]  grp_gap;
    logic              accept;

    assign o_stall = (r_state != S_IDLE);
    assign accept  = i_valid && (r_state == S_IDLE);
    assign macro   = script_op(r_kind, r_use_def, r_pc);

    // segment for the current step of the building block
    always_comb begin
        seg      = '{level: 1'b0, dur: '0, hold: 1'b0};
        done     = 1'b0;
        grp_last = SUB_W'(2 * GRP_START_N);
        grp_gap  = DUR_W'(GapStart);
        case (macro)
            M_STBY: begin
                seg.dur = STANDBY_US;
                done    = 1'b1;
            end
            M_START, M_END, M_ONCE: begin
                if (macro == M_END) begin
                    grp_last = SUB_W'(2 * GRP_END_N);
                    grp_gap  = DUR_W'(GapEnd);
                end else if (macro == M_ONCE) begin
                    grp_last = SUB_W'(2 * GRP_ONCE_N);
                    grp_gap  = DUR_W'(GapOnce);
                end
                if (r_sub == grp_last) begin
                    seg.dur = grp_gap;
                    done    = 1'b1;
                end else begin
                    seg.level = ~r_sub[0];
                    seg.dur   = r_sub[0] ? PulseLo : PulseHi;
                end
            end
            M_CAL: begin
                case (r_sub)
                    4'd0: seg.dur = CAL_GAP_US;
                    4'd1: begin
                        seg.level = 1'b1;
                        seg.dur   = CalPulse;
                    end
                    default: begin
                        seg.dur = CAL_GAP_US;
                        done    = 1'b1;
                    end
                endcase
            end
            M_CUR: begin
                seg.level = ~r_sub[0];
                seg.dur   = r_cur;
                done      = r_sub[0];
            end
            M_RAMP: begin
                case (r_sub[1:0])
                    2'd0: begin
                        seg.level = 1'b1;
                        seg.dur   = r_rise;
                    end
                    2'd1: seg.dur = r_on;
                    2'd2: begin
                        seg.level = 1'b1;
                        seg.dur   = r_fall;
                    end
                    default: seg.dur = r_off;
                endcase
                done = (r_sub == SUB_W'(11));
            end
            M_HOLD_HI, M_HOLD_LO: begin
                seg.level = (macro == M_HOLD_HI);
                seg.hold  = 1'b1;
                done      = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    assign o_push     = (r_state == S_RUN) && (macro != M_NONE) && !i_q_status.full;
    assign o_push_seg = seg;

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        n_sub   = r_sub;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_RUN;
                    n_pc    = '0;
                    n_sub   = '0;
                end
            end
            S_RUN: begin
                if (macro == M_NONE) begin
                    n_state = S_IDLE;
                end else if (!i_q_status.full) begin
                    if (done) begin
                        n_sub = '0;
                        n_pc  = r_pc + 1'b1;
                        if (seg.hold) begin
                            n_state = S_IDLE;
                        end
                    end else begin
                        n_sub = r_sub + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_sub   <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
            r_sub   <= n_sub;
        end
    end

    // command fields captured at accept, each duration adjusted once
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind    <= i_beat.kind;
            r_use_def <= i_beat.use_default;
            r_cur     <= DUR_W'(i_beat.current_code) + Adjust;
            r_rise    <= DUR_W'(i_beat.rise_time) + Adjust;
            r_fall    <= DUR_W'(i_beat.fall_time) + Adjust;
            r_on      <= DUR_W'(i_beat.on_time) + Adjust;
            r_off     <= DUR_W'(i_beat.off_time) + Adjust;
        end
    end

endmodule

`default_nettype wire

>>> src/swled_back.sv
// ----------------------------------------------------------------------------
// swled_back
// merges raw segments of equal level, drops empty ones, drives the output beat
// ----------------------------------------------------------------------------
`default_nettype none

module swled_back (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  swled_pkg::t_queue_status i_q_status,
    input  swled_pkg::t_raw_seg      i_head_seg,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire                      i_stall,
    output swled_pkg::t_out_beat     o_beat
);
    import swled_pkg::*;

    // pending segment, still open for merging
    logic             r_pv, n_pv;
    t_raw_seg         r_pend, n_pend;
    logic             r_out_valid, n_out_valid;
    t_out_beat        r_out, n_out;

    logic             out_free;
    logic             load;
    logic [DUR_W:0]   sum;

    assign out_free = !r_out_valid || !i_stall;
    assign sum      = {1'b0, r_pend.dur} + {1'b0, i_head_seg.dur};

    always_comb begin
        o_pop  = 1'b0;
        load   = 1'b0;
        n_pv   = r_pv;
        n_pend = r_pend;
        n_out  = r_out;
        if (r_pv && r_pend.hold) begin
            if (out_free) begin
                load  = 1'b1;
                n_out = '{pin_level: r_pend.level, duration_us: '0, hold: 1'b1, last: 1'b1};
                n_pv  = 1'b0;
            end
        end else if (i_q_status.avail) begin
            if (i_head_seg.hold) begin
                if (!r_pv) begin
                    o_pop  = 1'b1;
                    n_pv   = 1'b1;
                    n_pend = i_head_seg;
                end else if (out_free) begin
                    o_pop  = 1'b1;
                    load   = 1'b1;
                    n_out  = '{pin_level: r_pend.level, duration_us: r_pend.dur,
                               hold: 1'b0, last: 1'b0};
                    n_pend = i_head_seg;
                end
            end else if (i_head_seg.dur == '0) begin
                o_pop = 1'b1;
            end else if (r_pv && (r_pend.level == i_head_seg.level)) begin
                o_pop      = 1'b1;
                n_pend.dur = sum[DUR_W] ? DUR_MAX : sum[DUR_W-1:0];
            end else if (!r_pv) begin
                o_pop  = 1'b1;
                n_pv   = 1'b1;
                n_pend = i_head_seg;
            end else if (out_free) begin
                o_pop  = 1'b1;
                load   = 1'b1;
                n_out  = '{pin_level: r_pend.level, duration_us: r_pend.dur,
                           hold: 1'b0, last: 1'b0};
                n_pend = i_head_seg;
            end
        end
        n_out_valid = load ? 1'b1 : (r_out_valid && i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_beat  = r_out;

endmodule

`default_nettype wire
